// ----- rtl/plist_pkg.sv -----
// Shared types and codes for the positional list engine.
// Has no dependencies. The engine and the checker use it.
`timescale 1ns / 1ps
`default_nettype none
package plist_pkg;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;
	localparam logic [1:0] KIND_CLEAR  = 2'd3;

	typedef struct packed {
		logic [1:0]         kind;
		logic [5:0]         position;
		logic signed [31:0] value;
	} req_word_t;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] read_value;
		logic [5:0]         length;
	} rsp_word_t;

endpackage
`default_nettype wire

// ----- rtl/plist_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module plist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/positional_list_engine.sv -----
// Positional list engine: a bounded ordered list of signed 32-bit values.
// Depends on plist_pkg and plist_ram.
//
// Usage: a request word (kind, position, value) enters on req_valid/req_ready,
// and exactly one response word (ok, read_value, length) leaves on
// rsp_valid/rsp_ready for each request. One request is in work at a time;
// req_ready is high only while the engine is idle and no response is waiting.
//
// Clear and any failing request go straight to the response. A read passes
// through S_READ, which registers the RAM read data. Insert and remove pass
// through S_SHIFT, where the entries behind the position move one place
// through the single read and write port of the entry RAM, one entry per
// cycle, and S_SHIFT ends once the last pending write has settled.
//
// Reset empties the list at once (the length counter clears); RAM contents are
// not cleared, and only entries below the length are ever read. If the receiver
// stalls, the response word stays on rsp and no new request is taken.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_engine #(
	parameter int CAPACITY = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire plist_pkg::req_word_t  req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output plist_pkg::rsp_word_t       rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = (CW > 6) ? CW : 6;
	localparam logic [MW-1:0] CAP_X = MW'(CAPACITY);
	localparam logic [MW-1:0] ONE_X = MW'(1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SHIFT = 4'b0010,
		S_READ  = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;
	logic [MW-1:0]        pos_q;
	logic                 up_q;
	logic signed [31:0]   val_q;
	logic                 wv_s1;
	logic [AW-1:0]        wa_s1;
	plist_pkg::rsp_word_t rsp_q;

	logic [MW-1:0] cnt_x, pos_x, idx_x;
	logic          more, finish, accept;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;
	logic [CW-1:0] idx_next;

	assign cnt_x  = MW'(count_q);
	assign pos_x  = MW'(req.position);
	assign idx_x  = MW'(idx_q);
	assign accept = req_valid && req_ready;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_OUT);
	assign rsp       = rsp_q;

	always_comb begin
		if (up_q) begin
			more     = idx_x > pos_q;
			idx_next = idx_q - CW'(1);
		end else begin
			more     = (idx_x + ONE_X) < cnt_x;
			idx_next = idx_q + CW'(1);
		end
		finish = !more && !wv_s1;
	end

	// The read address runs ahead of the pending write address, so they never collide.
	always_comb begin
		if (state_q == S_IDLE) begin
			ram_raddr = pos_x[AW-1:0];
		end else begin
			ram_raddr = idx_next[AW-1:0];
		end
		ram_we    = 1'b0;
		ram_waddr = wa_s1;
		ram_wdata = ram_rdata;
		if (state_q == S_SHIFT) begin
			if (wv_s1) begin
				ram_we = 1'b1;
			end else if (up_q && !more) begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = val_q;
			end
		end
	end

	plist_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			wv_s1   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					wv_s1 <= 1'b0;
					if (accept) begin
						rsp_q.ok         <= 1'b0;
						rsp_q.read_value <= '0;
						rsp_q.length     <= cnt_x[5:0];
						state_q          <= S_OUT;
						case (req.kind)
							plist_pkg::KIND_INSERT: begin
								if (pos_x <= cnt_x && cnt_x < CAP_X) begin
									idx_q   <= count_q;
									up_q    <= 1'b1;
									state_q <= S_SHIFT;
								end
							end
							plist_pkg::KIND_REMOVE: begin
								if (pos_x < cnt_x) begin
									idx_q   <= pos_x[CW-1:0];
									up_q    <= 1'b0;
									state_q <= S_SHIFT;
								end
							end
							plist_pkg::KIND_READ: begin
								if (pos_x < cnt_x) begin
									state_q <= S_READ;
								end
							end
							default: begin
								count_q      <= '0;
								rsp_q.ok     <= 1'b1;
								rsp_q.length <= '0;
							end
						endcase
						pos_q <= pos_x;
						val_q <= req.value;
					end
				end
				S_SHIFT: begin
					wv_s1 <= more;
					wa_s1 <= idx_q[AW-1:0];
					if (more) begin
						idx_q <= idx_next;
					end
					if (finish) begin
						rsp_q.ok <= 1'b1;
						if (up_q) begin
							count_q      <= count_q + CW'(1);
							rsp_q.length <= 6'(cnt_x + ONE_X);
						end else begin
							count_q      <= count_q - CW'(1);
							rsp_q.length <= 6'(cnt_x - ONE_X);
						end
						state_q <= S_OUT;
					end
				end
				S_READ: begin
					rsp_q.ok         <= 1'b1;
					rsp_q.read_value <= ram_rdata;
					state_q          <= S_OUT;
				end
				S_OUT: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/plist_checker.sv -----
// Port-level checks for the positional list engine, bound to the top level.
// Depends on plist_pkg and positional_list_engine.
`timescale 1ns / 1ps
`default_nettype none
module plist_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 req_valid,
	input wire logic                 req_ready,
	input wire logic                 rsp_valid,
	input wire logic                 rsp_ready,
	input wire plist_pkg::rsp_word_t rsp
);

	// A failed operation never returns data.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ok |-> rsp.read_value == 32'sd0)
		else $error("failed response carries data");

	// Only one word is in work: after a request is taken, no other is taken next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	// A delivered response is not shown again.
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready |=> !rsp_valid)
		else $error("response repeated");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

endmodule

bind positional_list_engine plist_checker u_plist_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
`default_nettype wire
